FILE: sv/pagr_pkg.sv
// ----------------------------------------------------------------------------
// pagr_pkg
// Shared types and constants for the photocurrent auto gain ranging block.
// ----------------------------------------------------------------------------
package pagr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_VREF   = 3'd0;
  localparam logic [2:0] REG_UPPER  = 3'd1;
  localparam logic [2:0] REG_LOWER  = 3'd2;
  localparam logic [2:0] REG_GOAL   = 3'd3;
  localparam logic [2:0] REG_FLOOR  = 3'd4;

  // Reset values of the configuration registers and the gain step
  localparam logic [11:0] VREF_RST  = 12'd3300;
  localparam logic [11:0] UPPER_RST = 12'd200;
  localparam logic [11:0] LOWER_RST = 12'd50;
  localparam logic [11:0] GOAL_RST  = 12'd100;
  localparam logic [15:0] FLOOR_RST = 16'd10;
  localparam logic [7:0]  GAIN_RST  = 8'd128;

  // Divider datapath widths
  localparam int DIV_W     = 20;
  localparam int DIV_CNT_W = 5;

  // Full-scale converter divisor (65535)
  localparam logic [16:0] CONV_FS = 17'h0FFFF;

  // Current test: V*1e6 >= floor*(256-g)*3920*256, both sides divided by 320
  localparam logic [11:0] LHS_K = 12'd3125;
  localparam logic [11:0] RHS_K = 12'd3136;

  // Request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  // Status back from the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/pagr_div.sv
// ----------------------------------------------------------------------------
// pagr_div
// Shift-subtract divider, one quotient bit per cycle. The caller supplies the
// initial partial remainder (below the divisor) and the remaining dividend
// bits left-aligned, plus the number of quotient bits wanted.
// ----------------------------------------------------------------------------
module pagr_div
  import pagr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DIV_W-1:0] hi,
  input  logic [DIV_W-1:0] lo,
  input  logic [DIV_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     lo_sh;
  logic [DIV_W-1:0]     dv;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_W:0]       shifted;
  logic                 ge;
  logic [DIV_W:0]       diff;

  // One restoring step
  always_comb begin
    shifted = {rem, lo_sh[DIV_W-1]};
    ge      = shifted >= {1'b0, dv};
    diff    = shifted - {1'b0, dv};
  end

  // Iterate under the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= hi;
        lo_sh <= lo;
        dv    <= divisor;
        cnt   <= req.steps;
        quo   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        lo_sh <= {lo_sh[DIV_W-2:0], 1'b0};
        quo   <= {quo[DIV_W-2:0], ge};
        cnt   <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: sv/photocurrent_auto_gain_ranging.sv
// ----------------------------------------------------------------------------
// photocurrent_auto_gain_ranging
// Converts a converter sample to amplifier voltage and retunes the gain step.
// ----------------------------------------------------------------------------
// One sample is taken at a time and the input is not ready until its result
// is in the output register; it is ready again the cycle after. A sample runs
// the voltage multiply and two fold steps (skipped for a zero voltage), the
// range-test multiplies and the test; a new step for a nonzero voltage adds
// a multiply, a saturation check and, unless it saturates, the divider. The
// multiplies share one multiplier, the divide by the converter full scale is
// folded into two add steps, and the new step takes 8 shift-subtract divider steps.
// A result waiting on the output does not block the next sample from being
// taken, but that sample holds in its last step until the output is free.
// ----------------------------------------------------------------------------
module photocurrent_auto_gain_ranging
  import pagr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side, tdata: [15:0] sample
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // master side, tdata: [7:0] gain_step, [27:8] voltage_q8, [31:28] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  // master side, tuser: [0] gain_changed
  output logic        m_tuser,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_V, S_FOLD_V, S_FIX_V, S_MUL_L, S_MUL_R1, S_MUL_R2,
    S_TEST, S_MUL_N, S_SAT, S_DIV_N, S_WAIT_N, S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [11:0] vref_mv;
  logic [11:0] v_upper_mv;
  logic [11:0] v_lower_mv;
  logic [11:0] v_goal_mv;
  logic [15:0] current_floor_na;

  // Working registers
  logic [7:0]  gain;
  logic [15:0] biased;
  logic [19:0] vq8;
  logic [36:0] prod;
  logic [31:0] lhs;
  logic [29:0] dvd;
  logic [20:0] fold;
  logic        adj;

  // Shared multiplier
  logic [24:0] mul_a;
  logic [11:0] mul_b;
  logic [36:0] mul_p;

  // Divider hookup
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_hi;
  logic [DIV_W-1:0] div_lo;
  logic [DIV_W-1:0] div_dv;
  logic [DIV_W-1:0] div_quo;

  // Step arithmetic
  logic [8:0]  inv_g;
  logic [28:0] num;
  logic [27:0] v254;
  logic [16:0] wrap_sum;
  logic        wrap;
  logic        over;
  logic        under;
  logic        bright;
  logic        out_free;

  assign inv_g    = 9'd256 - {1'b0, gain};
  assign num      = {prod[20:0], 8'h00};
  assign v254     = {vq8, 8'h00} - {7'b0, vq8, 1'b0};
  assign over     = vq8 > {v_upper_mv, 8'h00};
  assign under    = vq8 <= {v_lower_mv, 8'h00};
  assign bright   = {5'b0, lhs} >= prod;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Divide by 2^16-1: fold the high half onto the low half twice, then
  // add one more when the last fold reaches the full scale
  assign wrap_sum = {1'b0, fold[15:0]} + {12'b0, fold[20:16]};
  assign wrap     = wrap_sum >= CONV_FS;

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_V: begin
        mul_a = {9'b0, biased - 16'd1};
        mul_b = vref_mv;
      end
      S_MUL_L: begin
        mul_a = {5'b0, vq8};
        mul_b = LHS_K;
      end
      S_MUL_R1: begin
        mul_a = {9'b0, current_floor_na};
        mul_b = {3'b0, inv_g};
      end
      S_MUL_R2: begin
        mul_a = prod[24:0];
        mul_b = RHS_K;
      end
      S_MUL_N: begin
        mul_a = {13'b0, v_goal_mv};
        mul_b = {3'b0, inv_g};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {12'b0, mul_a} * {25'b0, mul_b};

  // Load the divider for the step division
  always_comb begin
    div_req.start = (state == S_DIV_N);
    div_req.steps = DIV_CNT_W'(8);
  end

  assign div_hi = dvd[27:8];
  assign div_lo = {dvd[7:0], 12'h000};
  assign div_dv = vq8;

  pagr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .hi      (div_hi),
    .lo      (div_lo),
    .divisor (div_dv),
    .stat    (div_stat),
    .quo     (div_quo)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv          <= VREF_RST;
      v_upper_mv       <= UPPER_RST;
      v_lower_mv       <= LOWER_RST;
      v_goal_mv        <= GOAL_RST;
      current_floor_na <= FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VREF:  vref_mv          <= cfg_wdata[11:0];
        REG_UPPER: v_upper_mv       <= cfg_wdata[11:0];
        REG_LOWER: v_lower_mv       <= cfg_wdata[11:0];
        REG_GOAL:  v_goal_mv        <= cfg_wdata[11:0];
        REG_FLOOR: current_floor_na <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequence one sample through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      gain     <= GAIN_RST;
      adj      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid on a finished sample, drop it once taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            biased <= s_tdata ^ 16'h8000;
            adj    <= 1'b0;
            state  <= S_MUL_V;
          end
        end
        S_MUL_V: begin
          if (biased == 16'd0) begin
            vq8   <= '0;
            state <= S_MUL_L;
          end else begin
            prod  <= mul_p;
            state <= S_FOLD_V;
          end
        end
        S_FOLD_V: begin
          fold  <= {1'b0, prod[27:8]} + {5'b0, prod[7:0], 8'h00};
          state <= S_FIX_V;
        end
        S_FIX_V: begin
          vq8   <= prod[27:8] + {15'b0, fold[20:16]} + {19'b0, wrap};
          state <= S_MUL_L;
        end
        S_MUL_L: begin
          lhs   <= mul_p[31:0];
          state <= S_MUL_R1;
        end
        S_MUL_R1: begin
          prod  <= mul_p;
          state <= S_MUL_R2;
        end
        S_MUL_R2: begin
          prod  <= mul_p;
          state <= S_TEST;
        end
        S_TEST: begin
          if (over || (under && bright)) begin
            adj <= 1'b1;
            if (vq8 == 20'd0) begin
              gain  <= 8'd1;
              state <= S_DONE;
            end else begin
              state <= S_MUL_N;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL_N: begin
          prod  <= mul_p;
          state <= S_SAT;
        end
        S_SAT: begin
          // Ratio of 255 or more pins the step low; a zero ratio pins it high
          if (num > {1'b0, v254}) begin
            gain  <= 8'd1;
            state <= S_DONE;
          end else if (num == 29'd0) begin
            gain  <= 8'd255;
            state <= S_DONE;
          end else begin
            dvd   <= {1'b0, num} + {10'b0, vq8} - 30'd1;
            state <= S_DIV_N;
          end
        end
        S_DIV_N: state <= S_WAIT_N;
        S_WAIT_N: begin
          if (div_stat.done) begin
            gain  <= 8'(9'd256 - {1'b0, div_quo[7:0]});
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {4'b0, vq8, gain};
            m_tuser  <= adj;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_WAIT_N))
    else $error("divider finished outside a wait step");

  // Adjustment never drives the gain step to zero
  a_gain_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> gain != 8'd0)
    else $error("gain step reached zero");

  // One sample at a time: no request taken right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accepting a sample");

  // Divider is never restarted while busy
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !div_req.start)
    else $error("divider restarted while busy");
`endif

endmodule

FILE: sim/photocurrent_auto_gain_ranging_tb.sv
// ----------------------------------------------------------------------------
// photocurrent_auto_gain_ranging_tb
// Self-checking bench for the photocurrent auto gain ranging block.
// Streams converter samples under a series of register settings. Each
// accepted sample runs through an in-bench gain predictor, and each output
// request is checked field by field against the oldest predicted update.
// Both stream sides idle at random, and one long output stall lets the
// block fill up and push back on its input.
// ----------------------------------------------------------------------------
module photocurrent_auto_gain_ranging_tb;
  import pagr_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_GAP      = 6;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int RUN_LIMIT    = 12_000_000;

  // Indexes with no register behind them
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  gain_step;
    logic        gain_changed;
    logic [19:0] voltage_q8;
  } gain_update_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = '0;
  logic [15:0] cfg_wdata = '0;

  // Predictor copy of the registers and the gain in force
  logic [11:0] vref_cfg  = VREF_RST;
  logic [11:0] upper_cfg = UPPER_RST;
  logic [11:0] lower_cfg = LOWER_RST;
  logic [11:0] goal_cfg  = GOAL_RST;
  logic [15:0] floor_cfg = FLOOR_RST;
  logic [7:0]  gain_now  = GAIN_RST;

  logic [15:0]  pending_samples[$];
  gain_update_t expected_updates[$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  bit   tx_burst  = 1'b0;
  bit   rx_burst  = 1'b0;
  int   tx_gap    = 0;
  int   rx_wait   = 0;
  int   hold_left = 0;
  int   stall_ask  = 0;
  int   stall_seen = 0;

  int fail_count      = 0;
  int results_checked = 0;
  int gain_changes    = 0;
  int settings_count  = 0;

  photocurrent_auto_gain_ranging dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Work out voltage, range decision and new step; advance the gain in force
  function automatic gain_update_t predict_gain_update(input logic [15:0] raw);
    gain_update_t      res;
    longint unsigned   biased;
    longint unsigned   vq8;
    longint unsigned   span;
    longint unsigned   num;
    longint unsigned   ceil_ratio;
    logic              adjust;
    biased = 64'(raw ^ 16'h8000);
    if (biased == 0) begin
      vq8 = 0;
    end else begin
      vq8 = ((biased - 1) * 64'(vref_cfg) * 256) / 65535;
    end
    span = 64'(256) - 64'(gain_now);
    adjust = 1'b0;
    if (vq8 > 64'(upper_cfg) * 256) begin
      adjust = 1'b1;
    end else if (vq8 <= 64'(lower_cfg) * 256) begin
      adjust = (vq8 * 1000000) >= (64'(floor_cfg) * span * 3920 * 256);
    end
    if (adjust) begin
      if (vq8 == 0) begin
        gain_now = 8'd1;
      end else begin
        num = 64'(goal_cfg) * span * 256;
        ceil_ratio = (num + vq8 - 1) / vq8;
        if (ceil_ratio >= 255) begin
          gain_now = 8'd1;
        end else if (ceil_ratio == 0) begin
          gain_now = 8'd255;
        end else begin
          gain_now = 8'(256 - ceil_ratio);
        end
      end
    end
    res.gain_step    = gain_now;
    res.gain_changed = adjust;
    res.voltage_q8   = vq8[19:0];
    return res;
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each accepted sample, check each accepted result
  always @(posedge clk) begin
    gain_update_t want;
    if (rst) begin
      gain_now = GAIN_RST;
      expected_updates.delete();
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        expected_updates.push_back(predict_gain_update(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_updates.pop_front();
          check_field("gain_step", want.gain_step, m_tdata[7:0]);
          check_field("gain_changed", want.gain_changed, m_tuser);
          check_field("voltage_q8", want.voltage_q8, m_tdata[27:8]);
          check_field("tdata pad", 0, m_tdata[31:28]);
          results_checked++;
          if (want.gain_changed) begin
            gain_changes++;
          end
        end
      end
    end
  end

  // Offer samples; draw an idle gap after each accepted request
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && in_taken) begin
        tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!s_tvalid || in_taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept results; random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        hold_left = HOLD_CYCLES;
      end
      if (m_tready && out_taken) begin
        rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VREF:  vref_cfg  = val[11:0];
      REG_UPPER: upper_cfg = val[11:0];
      REG_LOWER: lower_cfg = val[11:0];
      REG_GOAL:  goal_cfg  = val[11:0];
      REG_FLOOR: floor_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] vref, input logic [15:0] upper,
                               input logic [15:0] lower, input logic [15:0] goal,
                               input logic [15:0] floor_na);
    set_reg(REG_VREF, vref);
    set_reg(REG_UPPER, upper);
    set_reg(REG_LOWER, lower);
    set_reg(REG_GOAL, goal);
    set_reg(REG_FLOOR, floor_na);
    settings_count++;
  endtask

  // Sample whose voltage lands near the given millivolt level
  function automatic logic [15:0] sample_at_mv(input int mv);
    int s;
    if (vref_cfg == 0) begin
      return 16'($urandom);
    end
    s = (mv * 65535) / int'(vref_cfg) - 32767;
    if (s > 32767) begin
      s = 32767;
    end else if (s < -32768) begin
      s = -32768;
    end
    return 16'(s);
  endfunction

  // Half the samples near the limits and the goal, the rest full range or at the field edges
  function automatic logic [15:0] random_sample();
    logic [15:0] jitter;
    jitter = 16'($urandom_range(0, 32)) - 16'd16;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5:       return sample_at_mv(int'(upper_cfg)) + jitter;
      6, 7:       return sample_at_mv(int'(lower_cfg)) + jitter;
      8:          return sample_at_mv(int'(goal_cfg)) + jitter;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h8001;
          2:       return 16'h7FFF;
          default: return 16'($urandom_range(0, 255)) ^ 16'h8000;
        endcase
      end
    endcase
  endfunction

  // Wait until every sample is taken and every update has come back
  task automatic wait_for_drain();
    while (pending_samples.size() != 0 || s_tvalid || expected_updates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) pending_samples.push_back(random_sample());
    wait_for_drain();
  endtask

  // Stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, field extremes and limit edges
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h8001);
    pending_samples.push_back(16'h7FFF);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hAAAA);
    pending_samples.push_back(sample_at_mv(int'(upper_cfg)));
    pending_samples.push_back(sample_at_mv(int'(upper_cfg)) + 16'd1);
    pending_samples.push_back(sample_at_mv(int'(lower_cfg)));
    pending_samples.push_back(sample_at_mv(int'(lower_cfg)) + 16'd1);
    pending_samples.push_back(sample_at_mv(int'(lower_cfg)) - 16'd1);
    wait_for_drain();

    // Full-scale reference, zero floor: zero voltage forces step 1
    apply_setting(16'd4095, 16'd4095, 16'd0, 16'd2048, 16'd0);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h8001);
    pending_samples.push_back(16'h7FFF);
    pending_samples.push_back(16'h0000);
    run_random(320);

    // Reset values written with junk above the register widths, spare
    // indexes written, and a long output hold-off
    apply_setting(16'hFCE4, 16'hA0C8, 16'h5032, 16'h3064, 16'd10);
    set_reg(REG_SPARE_LO, 16'($urandom));
    set_reg(REG_SPARE_HI, 16'($urandom));
    set_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'hFFFF);
    stall_ask++;
    run_random(325);

    // Zero reference, no idling on either side
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    apply_setting(16'd0, 16'd0, 16'd0, 16'd100, 16'd0);
    run_random(200);
    tx_burst = 1'b0;
    rx_burst = 1'b0;

    // Zero goal: steps saturate high
    apply_setting(16'd2500, 16'd1000, 16'd300, 16'd0, 16'd5);
    run_random(250);

    // Random settings
    repeat (3) begin
      apply_setting(16'($urandom_range(1000, 4095)), 16'($urandom_range(100, 3000)),
                    16'($urandom_range(0, 100)), 16'($urandom_range(0, 4095)),
                    16'($urandom_range(0, 2000)));
      run_random(120);
    end

    // Large goal with a wide undervoltage window: steps saturate low
    apply_setting(16'd3300, 16'd3000, 16'd2000, 16'd4095, 16'd0);
    run_random(250);

    // All registers at the top of their range
    apply_setting(16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'hFFFF);
    run_random(220);

    $display("Checked %0d gain updates (%0d with a new step) over %0d register settings,",
             results_checked, gain_changes, settings_count);
    $display("including zero and full-scale reference, goal and current floor.");
    if (fail_count == 0) begin
      $display("** photocurrent_auto_gain_ranging: PASSED **");
    end else begin
      $display("** photocurrent_auto_gain_ranging: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("Timeout with %0d updates outstanding", expected_updates.size());
    $display("** photocurrent_auto_gain_ranging: FAILED **");
    $finish;
  end

endmodule
